/* rtl/assert_macros.svh */
// Assertion macros used by the checker file (fsr_checker).
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

/* rtl/fsr_pkg.sv */
// Package for fraction_sum_reduce: microcode word types, step addresses
// and the control program ROM. No dependencies.
package fsr_pkg;

    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] pc_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LATCH,
        OP_MUL_ND,
        OP_MUL_DN,
        OP_MUL_DD,
        OP_COMMIT,
        OP_GINIT,
        OP_GSTEP,
        OP_DINIT_N,
        OP_DSTEP,
        OP_DSAVE_N,
        OP_FINISH
    } op_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_REQ,
        C_SKIP,
        C_NOT_LAST,
        C_GCD_RUN,
        C_DIV_RUN,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   target;
    } uword_t;

    localparam pc_t S_ACCEPT  = 4'd0;
    localparam pc_t S_MUL1    = 4'd1;
    localparam pc_t S_MUL2    = 4'd2;
    localparam pc_t S_MUL3    = 4'd3;
    localparam pc_t S_COMMIT  = 4'd4;
    localparam pc_t S_LASTCHK = 4'd5;
    localparam pc_t S_GINIT   = 4'd6;
    localparam pc_t S_GSTEP   = 4'd7;
    localparam pc_t S_DINIT_N = 4'd8;
    localparam pc_t S_DIV_N   = 4'd9;
    localparam pc_t S_DSAVE_N = 4'd10;
    localparam pc_t S_DIV_D   = 4'd11;
    localparam pc_t S_FINISH  = 4'd12;
    localparam pc_t S_WRAP    = 4'd13;

    // control program; a taken condition jumps to target, else pc + 1
    function automatic uword_t ucode(input pc_t pc);
        uword_t w;
        case (pc)
            S_ACCEPT:  w = '{OP_LATCH,   C_NO_REQ,   S_ACCEPT};
            S_MUL1:    w = '{OP_MUL_ND,  C_SKIP,     S_LASTCHK};
            S_MUL2:    w = '{OP_MUL_DN,  C_NEVER,    S_ACCEPT};
            S_MUL3:    w = '{OP_MUL_DD,  C_NEVER,    S_ACCEPT};
            S_COMMIT:  w = '{OP_COMMIT,  C_NOT_LAST, S_ACCEPT};
            S_LASTCHK: w = '{OP_NOP,     C_NOT_LAST, S_ACCEPT};
            S_GINIT:   w = '{OP_GINIT,   C_NEVER,    S_ACCEPT};
            S_GSTEP:   w = '{OP_GSTEP,   C_GCD_RUN,  S_GSTEP};
            S_DINIT_N: w = '{OP_DINIT_N, C_NEVER,    S_ACCEPT};
            S_DIV_N:   w = '{OP_DSTEP,   C_DIV_RUN,  S_DIV_N};
            S_DSAVE_N: w = '{OP_DSAVE_N, C_NEVER,    S_ACCEPT};
            S_DIV_D:   w = '{OP_DSTEP,   C_DIV_RUN,  S_DIV_D};
            S_FINISH:  w = '{OP_FINISH,  C_OUT_BUSY, S_FINISH};
            S_WRAP:    w = '{OP_NOP,     C_ALWAYS,   S_ACCEPT};
            default:   w = '{OP_NOP,     C_ALWAYS,   S_ACCEPT};
        endcase
        return w;
    endfunction

endpackage

/* rtl/fraction_sum_reduce.sv */
// Fraction sum with GCD reduction, run by a microcoded sequencer.
// Depends on fsr_pkg (microcode ROM and types).
//
// Usage:
//   Input requests (in_valid/in_ready) carry one signed fraction
//   numerator/denominator plus a last flag. A fraction with a zero
//   denominator is dropped. Fractions are summed by cross-multiplication
//   into a 64-bit numerator/denominator pair; a sum that leaves 64 bits
//   sets overflow and freezes the sum for the rest of the list.
//   On a last request the sum is reduced by the GCD of its magnitudes
//   (signs kept) and one result request goes out (out_valid/out_ready).
// Timing:
//   in_ready is high only at the accept step. A summed fraction runs
//   through accept, three passes of the single 64x16 multiplier and commit;
//   a dropped one skips from the first multiply step to the last check. A
//   last request adds the binary GCD loop (one step a cycle) and two 64-step
//   restoring divisions through one shared divider.
// Reset: the sum returns to 0/1, overflow clears, no result is pending.
// Stall: the result sits in an output register; new requests are taken
//   while it waits, and only the next result load waits for out_ready.
module fraction_sum_reduce (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] numerator,
    input  logic signed [15:0] denominator,
    input  logic               last,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [63:0] sum_numerator,
    output logic signed [63:0] sum_denominator,
    output logic               overflow
);

    fsr_pkg::pc_t    pc_reg, pc_next;
    fsr_pkg::uword_t uw;
    logic            cond_hit;

    // accumulator and control state
    logic signed [63:0] an_reg, an_next;
    logic signed [63:0] ad_reg, ad_next;
    logic               ovf_reg, ovf_next;
    logic               out_valid_reg, out_valid_next;

    // datapath registers
    logic signed [15:0] bn_reg, bn_next;
    logic signed [15:0] bd_reg, bd_next;
    logic               last_reg, last_next;
    logic signed [79:0] t1_reg, t1_next;
    logic signed [79:0] t2_reg, t2_next;
    logic signed [79:0] t3_reg, t3_next;
    logic        [80:0] sum_reg, sum_next;
    logic        [63:0] u_reg, u_next;
    logic        [63:0] v_reg, v_next;
    logic        [5:0]  k_reg, k_next;
    logic        [63:0] mn_reg, mn_next;
    logic        [63:0] md_reg, md_next;
    logic               sn_reg, sn_next;
    logic               sd_reg, sd_next;
    logic        [63:0] g_reg, g_next;
    logic        [63:0] dq_reg, dq_next;
    logic        [64:0] rem_reg, rem_next;
    logic        [5:0]  cnt_reg, cnt_next;
    logic        [63:0] qn_reg, qn_next;
    logic signed [63:0] out_num_reg, out_num_next;
    logic signed [63:0] out_den_reg, out_den_next;
    logic               out_ovf_reg, out_ovf_next;

    // shared multiplier
    logic signed [63:0] mul_a;
    logic signed [15:0] mul_b;
    logic signed [79:0] prod;

    logic        in_fire, out_fire, out_busy;
    logic        fits_sum, fits_den;
    logic [64:0] div_shift, div_diff;
    logic [63:0] gdiff_uv, gdiff_vu;

    assign in_ready  = (pc_reg == fsr_pkg::S_ACCEPT);
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;
    assign out_busy  = out_valid_reg && !out_ready;
    assign out_valid = out_valid_reg;
    assign sum_numerator   = out_num_reg;
    assign sum_denominator = out_den_reg;
    assign overflow        = out_ovf_reg;

    assign uw = fsr_pkg::ucode(pc_reg);

    always_comb
    begin
        case (uw.cond)
            fsr_pkg::C_NEVER:    cond_hit = 1'b0;
            fsr_pkg::C_ALWAYS:   cond_hit = 1'b1;
            fsr_pkg::C_NO_REQ:   cond_hit = !in_valid;
            fsr_pkg::C_SKIP:     cond_hit = (bd_reg == 16'sd0) || ovf_reg;
            fsr_pkg::C_NOT_LAST: cond_hit = !last_reg;
            fsr_pkg::C_GCD_RUN:  cond_hit = (u_reg != 64'd0);
            fsr_pkg::C_DIV_RUN:  cond_hit = (cnt_reg != 6'h3F);
            fsr_pkg::C_OUT_BUSY: cond_hit = out_busy;
            default:             cond_hit = 1'b0;
        endcase
        pc_next = cond_hit ? uw.target : pc_reg + 4'd1;
    end

    always_comb
    begin
        case (uw.op)
            fsr_pkg::OP_MUL_ND:
            begin
                mul_a = an_reg;
                mul_b = bd_reg;
            end
            fsr_pkg::OP_MUL_DN:
            begin
                mul_a = ad_reg;
                mul_b = bn_reg;
            end
            default:
            begin
                mul_a = ad_reg;
                mul_b = bd_reg;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // new sum must sit in signed 64 bits
    assign fits_sum = (sum_reg[80:63] == {18{sum_reg[63]}});
    assign fits_den = (t3_reg[79:63] == {17{t3_reg[63]}});

    assign div_shift = {rem_reg[63:0], dq_reg[63]};
    assign div_diff  = div_shift - {1'b0, g_reg};
    assign gdiff_uv  = u_reg - v_reg;
    assign gdiff_vu  = v_reg - u_reg;

    always_comb
    begin
        an_next        = an_reg;
        ad_next        = ad_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_fire ? 1'b0 : out_valid_reg;
        bn_next        = bn_reg;
        bd_next        = bd_reg;
        last_next      = last_reg;
        t1_next        = t1_reg;
        t2_next        = t2_reg;
        t3_next        = t3_reg;
        sum_next       = sum_reg;
        u_next         = u_reg;
        v_next         = v_reg;
        k_next         = k_reg;
        mn_next        = mn_reg;
        md_next        = md_reg;
        sn_next        = sn_reg;
        sd_next        = sd_reg;
        g_next         = g_reg;
        dq_next        = dq_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        qn_next        = qn_reg;
        out_num_next   = out_num_reg;
        out_den_next   = out_den_reg;
        out_ovf_next   = out_ovf_reg;

        case (uw.op)
            fsr_pkg::OP_LATCH:
            begin
                if (in_fire)
                begin
                    bn_next   = numerator;
                    bd_next   = denominator;
                    last_next = last;
                end
            end
            fsr_pkg::OP_MUL_ND:
                t1_next = prod;
            fsr_pkg::OP_MUL_DN:
                t2_next = prod;
            fsr_pkg::OP_MUL_DD:
            begin
                t3_next  = prod;
                sum_next = {t1_reg[79], t1_reg} + {t2_reg[79], t2_reg};
            end
            fsr_pkg::OP_COMMIT:
            begin
                if (fits_sum && fits_den)
                begin
                    an_next = sum_reg[63:0];
                    ad_next = t3_reg[63:0];
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
            fsr_pkg::OP_GINIT:
            begin
                sn_next = an_reg[63];
                sd_next = ad_reg[63];
                mn_next = an_reg[63] ? 64'd0 - an_reg : an_reg;
                md_next = ad_reg[63] ? 64'd0 - ad_reg : ad_reg;
                u_next  = an_reg[63] ? 64'd0 - an_reg : an_reg;
                v_next  = ad_reg[63] ? 64'd0 - ad_reg : ad_reg;
                k_next  = 6'd0;
            end
            fsr_pkg::OP_GSTEP:
            begin
                // binary GCD, one step per cycle
                if (u_reg != 64'd0)
                begin
                    if (!u_reg[0] && !v_reg[0])
                    begin
                        u_next = u_reg >> 1;
                        v_next = v_reg >> 1;
                        k_next = k_reg + 6'd1;
                    end
                    else if (!u_reg[0])
                        u_next = u_reg >> 1;
                    else if (!v_reg[0])
                        v_next = v_reg >> 1;
                    else if (u_reg >= v_reg)
                        u_next = gdiff_uv >> 1;
                    else
                        v_next = gdiff_vu >> 1;
                end
            end
            fsr_pkg::OP_DINIT_N:
            begin
                g_next   = v_reg << k_reg;
                dq_next  = mn_reg;
                rem_next = 65'd0;
                cnt_next = 6'd0;
            end
            fsr_pkg::OP_DSTEP:
            begin
                // restoring division, one quotient bit per cycle
                if (!div_diff[64])
                begin
                    rem_next = div_diff;
                    dq_next  = {dq_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = div_shift;
                    dq_next  = {dq_reg[62:0], 1'b0};
                end
                cnt_next = cnt_reg + 6'd1;
            end
            fsr_pkg::OP_DSAVE_N:
            begin
                qn_next  = sn_reg ? 64'd0 - dq_reg : dq_reg;
                dq_next  = md_reg;
                rem_next = 65'd0;
                cnt_next = 6'd0;
            end
            fsr_pkg::OP_FINISH:
            begin
                if (!out_busy)
                begin
                    out_num_next   = qn_reg;
                    out_den_next   = sd_reg ? 64'sd0 - $signed(dq_reg) : $signed(dq_reg);
                    out_ovf_next   = ovf_reg;
                    out_valid_next = 1'b1;
                    an_next        = 64'sd0;
                    ad_next        = 64'sd1;
                    ovf_next       = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= fsr_pkg::S_ACCEPT;
            an_reg        <= 64'sd0;
            ad_reg        <= 64'sd1;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            an_reg        <= an_next;
            ad_reg        <= ad_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bn_reg      <= bn_next;
        bd_reg      <= bd_next;
        last_reg    <= last_next;
        t1_reg      <= t1_next;
        t2_reg      <= t2_next;
        t3_reg      <= t3_next;
        sum_reg     <= sum_next;
        u_reg       <= u_next;
        v_reg       <= v_next;
        k_reg       <= k_next;
        mn_reg      <= mn_next;
        md_reg      <= md_next;
        sn_reg      <= sn_next;
        sd_reg      <= sd_next;
        g_reg       <= g_next;
        dq_reg      <= dq_next;
        rem_reg     <= rem_next;
        cnt_reg     <= cnt_next;
        qn_reg      <= qn_next;
        out_num_reg <= out_num_next;
        out_den_reg <= out_den_next;
        out_ovf_reg <= out_ovf_next;
    end

endmodule

/* rtl/fsr_checker.sv */
// Port-level checker for fraction_sum_reduce, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module fsr_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [63:0] sum_numerator,
    input logic signed [63:0] sum_denominator
);

    logic den_unit;

    assign den_unit = (sum_denominator == 64'sd1) || (sum_denominator == -64'sd1);

    // a pending result is not withdrawn
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

    // the sequencer leaves the accept step after taking a request
    `ASSERT_NEXT(a_one_req, clk, rst_n, in_valid && in_ready, !in_ready)

    // a reduced denominator is never zero
    `ASSERT_IMPL(a_den_nz, clk, rst_n, out_valid, sum_denominator != 64'sd0)

    // zero sum reduces to a unit denominator
    `ASSERT_IMPL(a_zero_sum, clk, rst_n, out_valid && (sum_numerator == 64'sd0), den_unit)

endmodule

bind fraction_sum_reduce fsr_checker u_fsr_checker (.*);
